/* hw/rtl/snt_pkg.sv */
// Shared types, codes and constants of the signal-sorted neighbor table.
package snt_pkg;

    localparam int DEF_TABLE_SLOTS = 8;
    localparam int DEF_NAME_CHARS  = 28;
    localparam int LABEL_W         = 224;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [7:0]  MAXLEN_RESET  = 8'd28;

    localparam logic [7:0] REG_TIMEOUT = 8'd0;
    localparam logic [7:0] REG_MAXLEN  = 8'd1;

    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_AGE    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_BAD_ID   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_AGED     = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  node_id;
        logic [55:0] name_word0;
        logic [55:0] name_word1;
        logic [55:0] name_word2;
        logic [55:0] name_word3;
        logic [4:0]  name_length;
        logic [8:0]  signal_level;
        logic [31:0] now;
        logic [2:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [3:0]  expired_count;
        logic        entry_active;
        logic [2:0]  entry_id;
        logic [8:0]  entry_signal;
        logic [55:0] entry_name0;
        logic [55:0] entry_name1;
        logic [55:0] entry_name2;
        logic [55:0] entry_name3;
    } out_item_t;

    typedef struct packed {
        logic [31:0] timeout_ticks;
        logic [7:0]  max_name_length;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_REPORT,
        CMD_AGE,
        CMD_READ,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         status;
        logic [2:0]         ident;
        logic [8:0]         strength;
        logic [31:0]        stamp;
        logic [LABEL_W-1:0] label;
        logic [2:0]         read_slot;
    } cmd_t;

    typedef struct packed {
        logic               live;
        logic [2:0]         ident;
        logic [8:0]         strength;
        logic [31:0]        stamp;
        logic [LABEL_W-1:0] label;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_BLOAD,
        S_BUBBLE,
        S_BEND,
        S_INSERT,
        S_AGE,
        S_DONE
    } seq_state_t;

endpackage

/* hw/rtl/snt_front.sv */
// Front part: checks and classifies each item and queues it as a command; items with operation code 3 are not queued.
module snt_front
    import snt_pkg::*;
#(
    parameter int NAME_CHARS = DEF_NAME_CHARS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    input  cfg_t     cfg,
    output logic     cmd_valid,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    cmd_t             q_reg [2];
    logic             wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    cmd_t             c;
    logic [LABEL_W-1:0] lab;
    logic [223:0]     raw;
    logic             ended;
    logic             too_long;
    logic             do_push;

    always_comb
    begin
        raw = {in_item.name_word3, in_item.name_word2,
               in_item.name_word1, in_item.name_word0};
        lab = '0;
        ended = 1'b0;
        for (int k = 0; k < 28; k++)
        begin
            if (k >= NAME_CHARS || raw[k*8 +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                lab[k*8 +: 8] = raw[k*8 +: 8];
        end
        too_long = (in_item.name_length >= 5'd4) &&
                   ({4'd0, in_item.name_length - 5'd4} > {1'b0, cfg.max_name_length});
        c = '0;
        c.ident = in_item.node_id[2:0];
        c.strength = in_item.signal_level;
        c.stamp = in_item.now;
        c.label = lab;
        c.read_slot = in_item.read_slot;
        case (in_item.operation)
            OP_REPORT:
            begin
                if (too_long)
                begin
                    c.kind = CMD_REJECT;
                    c.status = ST_TOO_LONG;
                end
                else if (lab[55:0] == 56'd0 || in_item.node_id < 8'd1 ||
                         in_item.node_id > 8'd7)
                begin
                    c.kind = CMD_REJECT;
                    c.status = ST_BAD_ID;
                end
                else
                begin
                    c.kind = CMD_REPORT;
                end
            end
            OP_AGE:  c.kind = CMD_AGE;
            default: c.kind = CMD_READ;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full && (in_item.operation != 2'd3);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ cmd_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("command queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !cmd_pop) |=> cmd_valid)
        else $error("queued command lost");

endmodule

/* hw/rtl/snt_back.sv */
// Back part: table of slots, slot-walking sequencer and result queue.
module snt_back
    import snt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW:0] LAST = (IW+1)'(TABLE_SLOTS - 1);
    localparam logic [IW:0] ONE  = (IW+1)'(1);

    entry_t       tab_reg [TABLE_SLOTS];
    seq_state_t   state_reg, state_next;
    logic [IW:0]  cnt_reg, cnt_next;
    cmd_t         cur_reg, cur_next;
    entry_t       carry_reg, carry_next;
    logic         found_reg, found_next;
    out_item_t    res_reg, res_next;
    logic         wr_en;
    logic [IW-1:0] wr_ix;
    entry_t       wr_data;
    logic [IW-1:0] ix;
    entry_t       e;
    entry_t       newrec;
    logic [31:0]  age;
    out_item_t    oq_reg [2];
    logic         owp_reg, orp_reg;
    logic [1:0]   ocnt_reg;
    logic         opush;

    assign ix = cnt_reg[IW-1:0];
    assign e  = tab_reg[ix];
    assign age = cur_reg.stamp - e.stamp;

    always_comb
    begin
        newrec = '{live: 1'b1, ident: cur_reg.ident, strength: cur_reg.strength,
                   stamp: cur_reg.stamp, label: cur_reg.label};
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        carry_next = carry_reg;
        found_next = found_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_ix      = ix;
        wr_data    = e;
        cmd_pop    = 1'b0;
        opush      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    cnt_next = '0;
                    res_next = '0;
                    found_next = 1'b0;
                    case (cmd.kind)
                        CMD_REJECT:
                        begin
                            res_next.status = cmd.status;
                            state_next = S_DONE;
                        end
                        CMD_READ:
                        begin
                            res_next.status = ST_READ;
                            res_next.slot = cmd.read_slot;
                            if (32'(cmd.read_slot) < 32'(TABLE_SLOTS))
                            begin
                                res_next.entry_active = tab_reg[IW'(cmd.read_slot)].live;
                                res_next.entry_id = tab_reg[IW'(cmd.read_slot)].ident;
                                res_next.entry_signal =
                                    tab_reg[IW'(cmd.read_slot)].strength;
                                {res_next.entry_name3, res_next.entry_name2,
                                 res_next.entry_name1, res_next.entry_name0} =
                                    tab_reg[IW'(cmd.read_slot)].label;
                            end
                            state_next = S_DONE;
                        end
                        CMD_AGE:
                        begin
                            res_next.status = ST_AGED;
                            state_next = S_AGE;
                        end
                        default: state_next = S_MATCH;
                    endcase
                end
            end
            S_MATCH:
            begin
                cnt_next = cnt_reg + ONE;
                if (e.label == cur_reg.label)
                begin
                    wr_en = 1'b1;
                    wr_data = newrec;
                    res_next.status = ST_UPDATED;
                    res_next.slot = 3'(ix);
                    state_next = S_BLOAD;
                end
                else if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    carry_next = newrec;
                    res_next.status = ST_INSERTED;
                    state_next = S_INSERT;
                end
            end
            S_BLOAD:
            begin
                carry_next = tab_reg[0];
                cnt_next = ONE;
                state_next = S_BUBBLE;
            end
            S_BUBBLE:
            begin
                wr_en = 1'b1;
                wr_ix = IW'(cnt_reg - ONE);
                if ($signed(carry_reg.strength) < $signed(e.strength) && e.live)
                    wr_data = e;
                else
                begin
                    wr_data = carry_reg;
                    carry_next = e;
                end
                cnt_next = cnt_reg + ONE;
                if (cnt_reg == LAST)
                    state_next = S_BEND;
            end
            S_BEND:
            begin
                wr_en = 1'b1;
                wr_ix = LAST[IW-1:0];
                wr_data = carry_reg;
                state_next = S_DONE;
            end
            S_INSERT:
            begin
                if ($signed(carry_reg.strength) > $signed(e.strength) || !e.live)
                begin
                    wr_en = 1'b1;
                    wr_data = carry_reg;
                    carry_next = e;
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        res_next.slot = 3'(ix);
                    end
                end
                cnt_next = cnt_reg + ONE;
                if (cnt_reg == LAST)
                    state_next = S_DONE;
            end
            S_AGE:
            begin
                if (e.live && age > cfg.timeout_ticks)
                begin
                    wr_en = 1'b1;
                    wr_data.live = 1'b0;
                    wr_data.label = '0;
                    if (res_reg.expired_count != 4'd15)
                        res_next.expired_count = res_reg.expired_count + 4'd1;
                end
                cnt_next = cnt_reg + ONE;
                if (cnt_reg == LAST)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (ocnt_reg != 2'd2)
                begin
                    opush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < TABLE_SLOTS; i++)
                tab_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
                tab_reg[wr_ix] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        cur_reg   <= cur_next;
        carry_reg <= carry_next;
        found_reg <= found_next;
        res_reg   <= res_next;
        if (opush)
            oq_reg[owp_reg] <= res_reg;
    end

    assign empty    = (ocnt_reg == 2'd0);
    assign out_item = oq_reg[orp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            owp_reg  <= owp_reg ^ opush;
            orp_reg  <= orp_reg ^ (pop && !empty);
            ocnt_reg <= ocnt_reg + {1'b0, opush} - {1'b0, pop && !empty};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> state_reg == S_IDLE)
        else $error("command taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n) ocnt_reg != 2'd3)
        else $error("result queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n) opush |=> state_reg == S_IDLE)
        else $error("sequencer did not return after result");

endmodule

/* hw/rtl/signal_sorted_neighbor_table.sv */
// Top level of the signal-sorted neighbor table with configuration registers.
// A read or rejected report needs no walk of the table; an age item walks every slot
// once, and a report walks the slots to match and then again to re-sort or insert,
// the sequencer walking one slot per cycle.
// Items are handled one at a time by the sequencer; two commands and two results queue.
// Reset clears all slots, the queues and the registers to their default values.
module signal_sorted_neighbor_table
    import snt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int NAME_CHARS  = DEF_NAME_CHARS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
            cfg_reg.max_name_length <= MAXLEN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TIMEOUT)
                cfg_reg.timeout_ticks <= cfg_data;
            else if (cfg_index == REG_MAXLEN)
                cfg_reg.max_name_length <= cfg_data[7:0];
        end
    end

    snt_front #(.NAME_CHARS(NAME_CHARS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cfg(cfg_reg), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
    );

    snt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop), .cmd(cmd), .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule
